// File: hw/rtl/idq_pkg.sv
// Package for the indexed double-ended queue: field widths, command and
// status codes, controller states and the control beat broadcast to the cells.
// No dependencies.
package idq_pkg;

   localparam int unsigned CAPACITY_DEF = 256;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned INDEX_W      = 8;
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned STATUS_W     = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_READ       = 3'd2,
      CMD_PUSH_FRONT = 3'd3,
      CMD_POP_FRONT  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_SEEK = 2'b10
   } fsm_type;

   typedef struct packed {
      logic push_front;
      logic pop_front;
      logic push_back;
      logic tap_load;
      logic tap_shift;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/indexed_double_ended_queue_top.sv
// Top level of the indexed double-ended queue: controller and a row of cells.
// Depends on idq_pkg, idq_cell and idq_ctrl.
//
//   channel   handshake            payload
//   request   req_start, busy      req_command, req_value, req_index
//   response  rsp_strobe           rsp_data, rsp_status
//
// Cell 0 holds the front entry; pushes and pops at the front shift the row.
// Push front, push back, pop front and all refused commands: busy stays low,
// result registered in the cycle after the accepting edge, next beat accepted right away.
// Read and pop back copy the row into the tap chain and shift it toward cell 0,
// one place a cycle: busy until the entry reaches cell 0, result registered as busy falls.
// Synchronous reset empties the queue; the receiver cannot stall results.
module indexed_double_ended_queue_top import idq_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   input  logic        [CMD_W-1:0]   req_command,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic        [INDEX_W-1:0] req_index,
   output logic                     busy,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0]  rsp_data,
   output logic        [STATUS_W-1:0] rsp_status
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);

   cell_ctrl_type            cell_ctrl;
   logic [ADDR_W-1:0]        back_pos;
   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic signed [DATA_W-1:0] tap_w   [CAPACITY];

   idq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_command (req_command),
      .req_index   (req_index),
      .front_entry (entry_w[0]),
      .front_tap   (tap_w[0]),
      .busy        (busy),
      .cell_ctrl   (cell_ctrl),
      .back_pos    (back_pos),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status)
   );

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic signed [DATA_W-1:0] left_w;
      logic signed [DATA_W-1:0] right_w;
      logic signed [DATA_W-1:0] right_tap_w;

      if (j == 0) begin : g_first
         assign left_w = req_value;
      end else begin : g_inner_left
         assign left_w = entry_w[j-1];
      end

      if (j == CAPACITY - 1) begin : g_last
         assign right_w     = '0;
         assign right_tap_w = '0;
      end else begin : g_inner_right
         assign right_w     = entry_w[j+1];
         assign right_tap_w = tap_w[j+1];
      end

      idq_cell #(
         .ADDR_W (ADDR_W),
         .POS    (j)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .back_pos    (back_pos),
         .push_value  (req_value),
         .left_entry  (left_w),
         .right_entry (right_w),
         .right_tap   (right_tap_w),
         .entry       (entry_w[j]),
         .tap         (tap_w[j])
      );
   end

endmodule

// File: hw/rtl/idq_cell.sv
// One queue cell: holds one entry and one tap word of the read chain.
// Depends on idq_pkg.
module idq_cell import idq_pkg::*; #(
   parameter int unsigned ADDR_W = 8,
   parameter int unsigned POS    = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic        [ADDR_W-1:0] back_pos,
   input  logic signed [DATA_W-1:0] push_value,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   input  logic signed [DATA_W-1:0] right_tap,
   output logic signed [DATA_W-1:0] entry,
   output logic signed [DATA_W-1:0] tap
);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic signed [DATA_W-1:0] tap_ff, tap_in;
   logic                     back_hit;

   assign back_hit = (back_pos == ADDR_W'(POS));

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.push_front) begin
         entry_in = left_entry;
      end else if (ctrl.pop_front) begin
         entry_in = right_entry;
      end else if (ctrl.push_back && back_hit) begin
         entry_in = push_value;
      end
   end

   always_comb begin
      tap_in = tap_ff;
      priority if (ctrl.tap_load) begin
         tap_in = entry_ff;
      end else if (ctrl.tap_shift) begin
         tap_in = right_tap;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

// File: hw/rtl/idq_ctrl.sv
// Queue controller: command decode, entry count, read seek counter and the
// registered result beat. Depends on idq_pkg.
module idq_ctrl import idq_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   input  logic        [CMD_W-1:0]             req_command,
   input  logic        [INDEX_W-1:0]           req_index,
   input  logic signed [DATA_W-1:0]            front_entry,
   input  logic signed [DATA_W-1:0]            front_tap,
   output logic                                busy,
   output cell_ctrl_type                       cell_ctrl,
   output logic        [$clog2(CAPACITY)-1:0]  back_pos,
   output logic                                rsp_strobe,
   output logic signed [DATA_W-1:0]            rsp_data,
   output logic        [STATUS_W-1:0]          rsp_status
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   fsm_type                  state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        seek_ff, seek_in;
   logic                     pop_ff, pop_in;
   logic                     strobe_ff, strobe_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   status_type               status_ff, status_in;

   logic             accept;
   logic             empty;
   logic             full;
   logic             out_of_range;
   logic [CMP_W-1:0] index_ext;
   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] last_pos;

   assign accept       = req_start && (state_ff == FSM_IDLE);
   assign empty        = (count_ff == '0);
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign index_ext    = CMP_W'(req_index);
   assign count_ext    = CMP_W'(count_ff);
   assign out_of_range = (index_ext >= count_ext);
   assign last_pos     = count_ff - CNT_W'(1);
   assign back_pos     = count_ff[ADDR_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      seek_in   = seek_ff;
      pop_in    = pop_ff;
      strobe_in = 1'b0;
      data_in   = data_ff;
      status_in = status_ff;
      cell_ctrl = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               data_in   = '0;
               status_in = ST_OK;
               unique case (cmd_type'(req_command))
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_ctrl.push_back = 1'b1;
                        count_in            = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cell_ctrl.tap_load = 1'b1;
                        seek_in            = last_pos[ADDR_W-1:0];
                        pop_in             = 1'b1;
                        strobe_in          = 1'b0;
                        state_in           = FSM_SEEK;
                     end
                  end
                  CMD_READ: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (out_of_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        cell_ctrl.tap_load = 1'b1;
                        seek_in            = index_ext[ADDR_W-1:0];
                        pop_in             = 1'b0;
                        strobe_in          = 1'b0;
                        state_in           = FSM_SEEK;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_ctrl.push_front = 1'b1;
                        count_in             = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cell_ctrl.pop_front = 1'b1;
                        data_in             = front_entry;
                        count_in            = last_pos;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_SEEK: begin
            if (seek_ff == '0) begin
               strobe_in = 1'b1;
               data_in   = front_tap;
               status_in = ST_OK;
               state_in  = FSM_IDLE;
               if (pop_ff) begin
                  count_in = last_pos;
               end
            end else begin
               cell_ctrl.tap_shift = 1'b1;
               seek_in             = seek_ff - ADDR_W'(1);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      seek_ff   <= seek_in;
      pop_ff    <= pop_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;
   assign rsp_status = status_ff;

endmodule

// File: hw/rtl/idq_checker.sv
// Port-level checker for the indexed double-ended queue, bound to the top.
// Depends on idq_pkg and indexed_double_ended_queue_top.
module idq_checker import idq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_start,
   input logic        [CMD_W-1:0]   req_command,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic signed [DATA_W-1:0]  rsp_data,
   input logic        [STATUS_W-1:0] rsp_status
);

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> rsp_data == '0)
      else $error("nonzero data on error status");

   a_quick_beat: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && (req_command == CMD_PUSH_BACK ||
       req_command == CMD_PUSH_FRONT || req_command == CMD_POP_FRONT))
      |=> rsp_strobe && !busy)
      else $error("single-cycle command gave no result");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result while busy");

   a_busy_from_seek: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(req_start) &&
       ($past(req_command) == CMD_READ || $past(req_command) == CMD_POP_BACK)))
      else $error("busy without read or pop back");

endmodule

bind indexed_double_ended_queue_top idq_checker u_idq_checker (.*);
